FILE: rtl/rmq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_pkg
// shared constants for the rotation matrix to quaternion pipeline
// ----------------------------------------------------------------------------
package rmq_pkg;

    localparam int DEF_ELEM_WIDTH = 16;
    localparam int DEF_FRAC_BITS  = 14;

    // which quaternion component comes from the square root
    localparam logic [1:0] SEL_X = 2'd0;
    localparam logic [1:0] SEL_Y = 2'd1;
    localparam logic [1:0] SEL_Z = 2'd2;
    localparam logic [1:0] SEL_W = 2'd3;

endpackage : rmq_pkg
`default_nettype wire

FILE: rtl/rmq_sqrt_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_sqrt_cell
// one restoring square root step: two radicand bits in, one root bit out
// ----------------------------------------------------------------------------
module rmq_sqrt_cell
    import rmq_pkg::*;
#(
    parameter int SW = 17
)
(
    input  wire logic              clk,
    input  wire logic [2*SW-1:0]   x_in,
    input  wire logic [SW:0]       rem_in,
    input  wire logic [SW-1:0]     root_in,
    output logic      [2*SW-1:0]   x_out,
    output logic      [SW:0]       rem_out,
    output logic      [SW-1:0]     root_out
);

    logic [2*SW-1:0] x_reg;
    logic [SW:0]     rem_reg;
    logic [SW-1:0]   root_reg;
    logic [SW+2:0]   shifted;
    logic [SW+2:0]   trial;
    logic [SW+2:0]   diff;
    logic            take;
    logic [SW:0]     rem_next;
    logic [SW-1:0]   root_next;

    always_comb
    begin
        shifted   = {rem_in, x_in[2*SW-1 -: 2]};
        trial     = {1'b0, root_in, 2'b01};
        take      = (shifted >= trial);
        diff      = shifted - trial;
        rem_next  = take ? diff[SW:0] : shifted[SW:0];
        root_next = {root_in[SW-2:0], take};
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= {x_in[2*SW-3:0], 2'b00};
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign x_out    = x_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule : rmq_sqrt_cell
`default_nettype wire

FILE: rtl/rmq_div_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_div_cell
// one restoring division step: one numerator bit in, one quotient bit out
// ----------------------------------------------------------------------------
module rmq_div_cell
    import rmq_pkg::*;
#(
    parameter int NW   = 32,
    parameter int DENW = 18
)
(
    input  wire logic            clk,
    input  wire logic [NW-1:0]   num_in,
    input  wire logic [DENW-1:0] den_in,
    input  wire logic [DENW-1:0] rem_in,
    input  wire logic [NW-1:0]   quo_in,
    output logic      [NW-1:0]   num_out,
    output logic      [DENW-1:0] den_out,
    output logic      [DENW-1:0] rem_out,
    output logic      [NW-1:0]   quo_out
);

    logic [NW-1:0]   num_reg;
    logic [DENW-1:0] den_reg;
    logic [DENW-1:0] rem_reg;
    logic [NW-1:0]   quo_reg;
    logic [DENW:0]   part;
    logic [DENW:0]   diff;
    logic            take;
    logic [DENW-1:0] rem_next;

    always_comb
    begin
        part     = {rem_in, num_in[NW-1]};
        take     = (part >= {1'b0, den_in});
        diff     = part - {1'b0, den_in};
        rem_next = take ? diff[DENW-1:0] : part[DENW-1:0];
    end

    always_ff @(posedge clk)
    begin
        num_reg <= {num_in[NW-2:0], 1'b0};
        den_reg <= den_in;
        rem_reg <= rem_next;
        quo_reg <= {quo_in[NW-2:0], take};
    end

    assign num_out = num_reg;
    assign den_out = den_reg;
    assign rem_out = rem_reg;
    assign quo_out = quo_reg;

endmodule : rmq_div_cell
`default_nettype wire

FILE: rtl/rotation_matrix_to_quaternion_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_top
// Shepperd rotation matrix to quaternion, fixed point, fully pipelined
// ----------------------------------------------------------------------------
// the pipeline runs from a front register through one square root cell per root bit,
//   a middle register and one divider cell per quotient bit to the output register
// throughput: one matrix every cycle, busy is never raised
// results appear for one cycle with done; the receiver cannot stall
// reset clears the valid chain only, no words are in flight afterwards
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_top
    import rmq_pkg::*;
#(
    parameter int ELEM_WIDTH = DEF_ELEM_WIDTH,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic signed [ELEM_WIDTH-1:0] row1_col1,
    input  wire logic signed [ELEM_WIDTH-1:0] row1_col2,
    input  wire logic signed [ELEM_WIDTH-1:0] row1_col3,
    input  wire logic signed [ELEM_WIDTH-1:0] row2_col1,
    input  wire logic signed [ELEM_WIDTH-1:0] row2_col2,
    input  wire logic signed [ELEM_WIDTH-1:0] row2_col3,
    input  wire logic signed [ELEM_WIDTH-1:0] row3_col1,
    input  wire logic signed [ELEM_WIDTH-1:0] row3_col2,
    input  wire logic signed [ELEM_WIDTH-1:0] row3_col3,
    output logic                              done,
    output logic signed [ELEM_WIDTH-1:0]      quat_x,
    output logic signed [ELEM_WIDTH-1:0]      quat_y,
    output logic signed [ELEM_WIDTH-1:0]      quat_z,
    output logic signed [ELEM_WIDTH-1:0]      quat_w
);

    localparam int W     = ELEM_WIDTH;
    localparam int F     = FRAC_BITS;
    localparam int RADW  = ((W > F) ? W : F + 1) + 3;
    localparam int SW    = (RADW + F + 1) / 2;
    localparam int XW    = 2 * SW;
    localparam int DW    = W + 1;
    localparam int NW    = (((DW + F) > SW) ? (DW + F) : SW) + 1;
    localparam int DENW  = SW + 1;
    localparam int LAT   = 3 + SW + NW;

    localparam logic signed [RADW-1:0] ONE_R = RADW'(1) << F;
    localparam logic [NW-1:0] LIM_NEG = NW'(1) << (W - 1);
    localparam logic [NW-1:0] LIM_POS = LIM_NEG - NW'(1);

    // ------------------------------------------------------------------
    // front stage: case select, radicand and the three off-diagonal terms
    // ------------------------------------------------------------------
    logic signed [RADW-1:0] e11, e22, e33, trace, rad_raw;
    logic signed [DW-1:0]   d_sub23, d_sub31, d_sub12, d_add12, d_add13, d_add23;
    logic [1:0]             sel_next;
    logic signed [DW-1:0]   d0_next, d1_next, d2_next;
    logic [RADW-1:0]        rad_next;

    always_comb
    begin
        e11     = RADW'(row1_col1);
        e22     = RADW'(row2_col2);
        e33     = RADW'(row3_col3);
        trace   = e11 + e22 + e33;
        d_sub23 = DW'(row2_col3) - DW'(row3_col2);
        d_sub31 = DW'(row3_col1) - DW'(row1_col3);
        d_sub12 = DW'(row1_col2) - DW'(row2_col1);
        d_add12 = DW'(row1_col2) + DW'(row2_col1);
        d_add13 = DW'(row1_col3) + DW'(row3_col1);
        d_add23 = DW'(row2_col3) + DW'(row3_col2);
        if (trace > 0)
        begin
            sel_next = SEL_W;
            rad_raw  = ONE_R + trace;
            d0_next  = d_sub23;
            d1_next  = d_sub31;
            d2_next  = d_sub12;
        end
        else if (e11 >= e22 && e11 >= e33)
        begin
            sel_next = SEL_X;
            rad_raw  = ONE_R + e11 - e22 - e33;
            d0_next  = d_add12;
            d1_next  = d_add13;
            d2_next  = d_sub23;
        end
        else if (e22 > e33)
        begin
            sel_next = SEL_Y;
            rad_raw  = ONE_R + e22 - e11 - e33;
            d0_next  = d_add12;
            d1_next  = d_add23;
            d2_next  = d_sub31;
        end
        else
        begin
            sel_next = SEL_Z;
            rad_raw  = ONE_R + e33 - e11 - e22;
            d0_next  = d_add13;
            d1_next  = d_add23;
            d2_next  = d_sub12;
        end
        // radicand clamped to the smallest positive value
        rad_next = (rad_raw <= 0) ? RADW'(1) : rad_raw;
    end

    logic [RADW-1:0]      a_rad_reg;
    logic [1:0]           sq_sel_reg   [0:SW];
    logic signed [DW-1:0] sq_d0_reg    [0:SW];
    logic signed [DW-1:0] sq_d1_reg    [0:SW];
    logic signed [DW-1:0] sq_d2_reg    [0:SW];
    logic                 sq_valid_reg [0:SW];

    always_ff @(posedge clk)
    begin
        a_rad_reg     <= rad_next;
        sq_sel_reg[0] <= sel_next;
        sq_d0_reg[0]  <= d0_next;
        sq_d1_reg[0]  <= d1_next;
        sq_d2_reg[0]  <= d2_next;
        for (int k = 0; k < SW; k++)
        begin
            sq_sel_reg[k+1] <= sq_sel_reg[k];
            sq_d0_reg[k+1]  <= sq_d0_reg[k];
            sq_d1_reg[k+1]  <= sq_d1_reg[k];
            sq_d2_reg[k+1]  <= sq_d2_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= SW; k++)
                sq_valid_reg[k] <= 1'b0;
        end
        else
        begin
            sq_valid_reg[0] <= start && !busy;
            for (int k = 0; k < SW; k++)
                sq_valid_reg[k+1] <= sq_valid_reg[k];
        end
    end

    // ------------------------------------------------------------------
    // square root chain, one root bit per cell
    // ------------------------------------------------------------------
    logic [XW-1:0] sq_x    [0:SW];
    logic [SW:0]   sq_rem  [0:SW];
    logic [SW-1:0] sq_root [0:SW];

    assign sq_x[0]    = XW'(a_rad_reg) << F;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    for (genvar g = 0; g < SW; g++)
    begin : g_sqrt
        rmq_sqrt_cell #(.SW(SW)) u_cell (
            .clk      (clk),
            .x_in     (sq_x[g]),
            .rem_in   (sq_rem[g]),
            .root_in  (sq_root[g]),
            .x_out    (sq_x[g+1]),
            .rem_out  (sq_rem[g+1]),
            .root_out (sq_root[g+1])
        );
    end

    // ------------------------------------------------------------------
    // middle stage: numerators, divisor 2S and the root component
    // ------------------------------------------------------------------
    logic [SW-1:0]   s_val;
    logic [SW:0]     root_sum;
    logic [DW-1:0]   mag0, mag1, mag2;
    logic [NW-1:0]   num0_next, num1_next, num2_next;

    always_comb
    begin
        s_val     = (sq_root[SW] == '0) ? SW'(1) : sq_root[SW];
        root_sum  = {1'b0, s_val} + (SW+1)'(1);
        mag0      = sq_d0_reg[SW][DW-1] ? DW'(-sq_d0_reg[SW]) : DW'(sq_d0_reg[SW]);
        mag1      = sq_d1_reg[SW][DW-1] ? DW'(-sq_d1_reg[SW]) : DW'(sq_d1_reg[SW]);
        mag2      = sq_d2_reg[SW][DW-1] ? DW'(-sq_d2_reg[SW]) : DW'(sq_d2_reg[SW]);
        num0_next = (NW'(mag0) << F) + NW'(s_val);
        num1_next = (NW'(mag1) << F) + NW'(s_val);
        num2_next = (NW'(mag2) << F) + NW'(s_val);
    end

    logic [NW-1:0]   b_num_reg [0:2];
    logic [DENW-1:0] b_den_reg;
    logic [1:0]      dv_sel_reg   [0:NW];
    logic [2:0]      dv_neg_reg   [0:NW];
    logic [SW-1:0]   dv_root_reg  [0:NW];
    logic            dv_valid_reg [0:NW];

    always_ff @(posedge clk)
    begin
        b_num_reg[0]   <= num0_next;
        b_num_reg[1]   <= num1_next;
        b_num_reg[2]   <= num2_next;
        b_den_reg      <= {s_val, 1'b0};
        dv_sel_reg[0]  <= sq_sel_reg[SW];
        dv_neg_reg[0]  <= {sq_d2_reg[SW][DW-1], sq_d1_reg[SW][DW-1], sq_d0_reg[SW][DW-1]};
        dv_root_reg[0] <= root_sum[SW:1];
        for (int k = 0; k < NW; k++)
        begin
            dv_sel_reg[k+1]  <= dv_sel_reg[k];
            dv_neg_reg[k+1]  <= dv_neg_reg[k];
            dv_root_reg[k+1] <= dv_root_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NW; k++)
                dv_valid_reg[k] <= 1'b0;
        end
        else
        begin
            dv_valid_reg[0] <= sq_valid_reg[SW];
            for (int k = 0; k < NW; k++)
                dv_valid_reg[k+1] <= dv_valid_reg[k];
        end
    end

    // ------------------------------------------------------------------
    // three divider chains, one quotient bit per cell
    // ------------------------------------------------------------------
    logic [NW-1:0] quo_res [0:2];

    for (genvar l = 0; l < 3; l++)
    begin : g_lane
        logic [NW-1:0]   dv_num [0:NW];
        logic [DENW-1:0] dv_den [0:NW];
        logic [DENW-1:0] dv_rem [0:NW];
        logic [NW-1:0]   dv_quo [0:NW];

        assign dv_num[0] = b_num_reg[l];
        assign dv_den[0] = b_den_reg;
        assign dv_rem[0] = '0;
        assign dv_quo[0] = '0;

        for (genvar g = 0; g < NW; g++)
        begin : g_div
            rmq_div_cell #(.NW(NW), .DENW(DENW)) u_cell (
                .clk     (clk),
                .num_in  (dv_num[g]),
                .den_in  (dv_den[g]),
                .rem_in  (dv_rem[g]),
                .quo_in  (dv_quo[g]),
                .num_out (dv_num[g+1]),
                .den_out (dv_den[g+1]),
                .rem_out (dv_rem[g+1]),
                .quo_out (dv_quo[g+1])
            );
        end

        assign quo_res[l] = dv_quo[NW];
    end

    // ------------------------------------------------------------------
    // output stage: sign, saturation and component placement
    // ------------------------------------------------------------------
    function automatic logic [W-1:0] sat_mag(input logic [NW-1:0] q, input logic neg);
        logic [NW-1:0] nq;
        begin
            nq = ~q + NW'(1);
            if (neg)
                sat_mag = (q > LIM_NEG) ? LIM_NEG[W-1:0] : nq[W-1:0];
            else
                sat_mag = (q > LIM_POS) ? LIM_POS[W-1:0] : q[W-1:0];
        end
    endfunction

    logic [W-1:0] l0, l1, l2, rv;
    logic [W-1:0] qx_next, qy_next, qz_next, qw_next;

    always_comb
    begin
        l0 = sat_mag(quo_res[0], dv_neg_reg[NW][0]);
        l1 = sat_mag(quo_res[1], dv_neg_reg[NW][1]);
        l2 = sat_mag(quo_res[2], dv_neg_reg[NW][2]);
        rv = sat_mag(NW'(dv_root_reg[NW]), 1'b0);
        case (dv_sel_reg[NW])
            SEL_W:
            begin
                qx_next = l0; qy_next = l1; qz_next = l2; qw_next = rv;
            end
            SEL_X:
            begin
                qx_next = rv; qy_next = l0; qz_next = l1; qw_next = l2;
            end
            SEL_Y:
            begin
                qx_next = l0; qy_next = rv; qz_next = l1; qw_next = l2;
            end
            default:
            begin
                qx_next = l0; qy_next = l1; qz_next = rv; qw_next = l2;
            end
        endcase
    end

    logic [W-1:0] qx_reg, qy_reg, qz_reg, qw_reg;
    logic         done_reg;

    always_ff @(posedge clk)
    begin
        qx_reg <= qx_next;
        qy_reg <= qy_next;
        qz_reg <= qz_next;
        qw_reg <= qw_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dv_valid_reg[NW];
    end

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign quat_x = qx_reg;
    assign quat_y = qy_reg;
    assign quat_z = qz_reg;
    assign quat_w = qw_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LAT done)
        else $error("word did not emerge after the pipeline latency");

    a_root_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
        sq_valid_reg[SW] |=> b_den_reg != '0)
        else $error("divisor reached the divider chain as zero");

    a_root_positive : assert property (@(posedge clk) disable iff (!rst_n)
        (dv_valid_reg[NW] && (dv_sel_reg[NW] == SEL_W)) |=> !qw_reg[W-1])
        else $error("square root component came out negative");

endmodule : rotation_matrix_to_quaternion_top
`default_nettype wire

FILE: bench/tb_rotation_matrix_to_quaternion_top.sv
// ----------------------------------------------------------------------------
// tb_rotation_matrix_to_quaternion_top
// Drives matrices into the quaternion pipeline and checks each quaternion
// word against an in-bench Shepperd predictor, in order, all four fields at once.
// ----------------------------------------------------------------------------
module tb_rotation_matrix_to_quaternion_top;
    import rmq_pkg::*;

    localparam int EW = DEF_ELEM_WIDTH;
    localparam int FB = DEF_FRAC_BITS;
    localparam int LATENCY = 60;

    typedef logic signed [EW-1:0] elem_t;

    typedef struct packed {
        elem_t qx;
        elem_t qy;
        elem_t qz;
        elem_t qw;
    } quat_t;

    class quat_scoreboard;
        quat_t pending_quats[$];
        int    mismatches;

        static function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        static function longint half_div(longint d, longint unsigned s);
            longint unsigned mag;
            longint unsigned q;
            mag = (d < 0) ? longint'(-d) : longint'(d);
            q = ((mag << FB) + s) / (s * 2);
            return (d < 0) ? -longint'(q) : longint'(q);
        endfunction

        static function elem_t clip(longint v);
            longint hi;
            longint lo;
            hi = (longint'(1) << (EW - 1)) - 1;
            lo = -hi - 1;
            if (v > hi)
                v = hi;
            if (v < lo)
                v = lo;
            return elem_t'(v);
        endfunction

        function void note_matrix(elem_t m[9]);
            longint a11, a12, a13, a21, a22, a23, a31, a32, a33;
            longint tr, rad, root, x, y, z, w;
            longint unsigned s;
            logic [1:0] sel;
            quat_t q;
            a11 = m[0]; a12 = m[1]; a13 = m[2];
            a21 = m[3]; a22 = m[4]; a23 = m[5];
            a31 = m[6]; a32 = m[7]; a33 = m[8];
            tr = a11 + a22 + a33;
            if (tr > 0)
            begin
                sel = SEL_W;
                rad = (longint'(1) << FB) + tr;
            end
            else if (a11 >= a22 && a11 >= a33)
            begin
                sel = SEL_X;
                rad = (longint'(1) << FB) + a11 - a22 - a33;
            end
            else if (a22 > a33)
            begin
                sel = SEL_Y;
                rad = (longint'(1) << FB) + a22 - a11 - a33;
            end
            else
            begin
                sel = SEL_Z;
                rad = (longint'(1) << FB) + a33 - a11 - a22;
            end
            // non-positive radicand clamps to the smallest step
            if (rad <= 0)
                rad = 1;
            s = int_sqrt(longint'(rad) << FB);
            if (s == 0)
                s = 1;
            root = longint'((s + 1) >> 1);
            case (sel)
                SEL_W:
                begin
                    w = root;
                    x = half_div(a23 - a32, s);
                    y = half_div(a31 - a13, s);
                    z = half_div(a12 - a21, s);
                end
                SEL_X:
                begin
                    x = root;
                    y = half_div(a12 + a21, s);
                    z = half_div(a13 + a31, s);
                    w = half_div(a23 - a32, s);
                end
                SEL_Y:
                begin
                    x = half_div(a21 + a12, s);
                    y = root;
                    z = half_div(a32 + a23, s);
                    w = half_div(a31 - a13, s);
                end
                default:
                begin
                    x = half_div(a31 + a13, s);
                    y = half_div(a32 + a23, s);
                    z = root;
                    w = half_div(a12 - a21, s);
                end
            endcase
            q.qx = clip(x);
            q.qy = clip(y);
            q.qz = clip(z);
            q.qw = clip(w);
            pending_quats.push_back(q);
        endfunction

        function void check_quat(quat_t got);
            quat_t want;
            if (pending_quats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word x=%0d y=%0d z=%0d w=%0d",
                             got.qx, got.qy, got.qz, got.qw);
                return;
            end
            want = pending_quats.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("word mismatch exp x=%0d y=%0d z=%0d w=%0d got x=%0d y=%0d z=%0d w=%0d",
                             want.qx, want.qy, want.qz, want.qw,
                             got.qx, got.qy, got.qz, got.qw);
            end
        endfunction
    endclass

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    logic  done;
    elem_t mat[9];
    elem_t quat_x, quat_y, quat_z, quat_w;

    quat_scoreboard board;

    rotation_matrix_to_quaternion_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .row1_col1(mat[0]), .row1_col2(mat[1]), .row1_col3(mat[2]),
        .row2_col1(mat[3]), .row2_col2(mat[4]), .row2_col3(mat[5]),
        .row3_col1(mat[6]), .row3_col2(mat[7]), .row3_col3(mat[8]),
        .done(done), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
        .quat_w(quat_w)
    );

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        for (int i = 0; i < 9; i++)
            mat[i] = '0;
        board = new();
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_quat('{quat_x, quat_y, quat_z, quat_w});
    end

    // holds one word on the ports until it is taken, after a random gap unless no_gap is set
    task automatic send_matrix(elem_t m[9], bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        for (int i = 0; i < 9; i++)
            mat[i] <= m[i];
        do
            @(posedge clk);
        while (busy);
        board.note_matrix(m);
    endtask

    function automatic elem_t near(int centre, int spread);
        return elem_t'(centre + $urandom_range(0, 2 * spread) - spread);
    endfunction

    task automatic run_directed();
        elem_t m[9];
        elem_t pats[6] = '{16'sh7fff, -16'sh8000, 16'sh0000, 16'sh4000, -16'sh4000, 16'sh0001};
        // identity, then the three half-turns picking x, y and z
        for (int k = 0; k < 4; k++)
        begin
            for (int i = 0; i < 9; i++)
                m[i] = 0;
            m[0] = (k == 0 || k == 1) ? 16'sh4000 : -16'sh4000;
            m[4] = (k == 0 || k == 2) ? 16'sh4000 : -16'sh4000;
            m[8] = (k == 0 || k == 3) ? 16'sh4000 : -16'sh4000;
            send_matrix(m, 1'b0);
        end
        // all elements set alike to each pattern, both extremes among them, saturation and clamped radicand
        for (int p = 0; p < 6; p++)
        begin
            for (int i = 0; i < 9; i++)
                m[i] = pats[p];
            send_matrix(m, 1'b0);
        end
        for (int i = 0; i < 9; i++)
            m[i] = 0;
        m[0] = -16'sh8000; m[4] = -16'sh8000; m[8] = -16'sh8000;
        m[5] = 16'sh7fff; m[7] = -16'sh8000;
        send_matrix(m, 1'b0);
        m[0] = 16'sh7fff; m[4] = 16'sh7fff; m[8] = 16'sh7fff;
        m[1] = 16'sh7fff; m[3] = -16'sh8000;
        send_matrix(m, 1'b0);
        for (int i = 0; i < 9; i++)
            m[i] = 0;
        // zero trace, ties between diagonal elements, then one matrix sent back to back twice
        m[0] = 0; m[4] = 0; m[8] = 0; m[1] = 16'sh1234; m[3] = -16'sh0777;
        send_matrix(m, 1'b0);
        m[0] = -16'sh2000; m[4] = 16'sh1000; m[8] = 16'sh1000;
        send_matrix(m, 1'b0);
        m[0] = -16'sh2000; m[4] = -16'sh1000; m[8] = 16'sh3000;
        send_matrix(m, 1'b1);
        send_matrix(m, 1'b1);
    endtask

    task automatic run_random(int count);
        elem_t m[9];
        int kind;
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(0, 9);
            for (int i = 0; i < 9; i++)
                m[i] = elem_t'($urandom());
            if (kind < 6)
            begin
                // near-rotation: diagonal pulled toward plus or minus one
                for (int i = 0; i < 3; i++)
                    m[4 * i] = near(($urandom_range(0, 1) ? 1 : -1) * 16384, 8000);
                for (int i = 0; i < 9; i++)
                    if (i % 4 != 0)
                        m[i] = near(0, 16384);
            end
            else if (kind == 6)
            begin
                for (int i = 0; i < 9; i++)
                    m[i] = $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000;
            end
            send_matrix(m, $urandom_range(0, 3) == 0);
            if (n == count / 2)
            begin
                start <= 1'b0;
                while (board.pending_quats.size() != 0)
                    @(posedge clk);
            end
        end
    endtask

    initial
    begin
        int waited;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random(650);
        start <= 1'b0;
        waited = 0;
        while (board.pending_quats.size() != 0 && waited < 10000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (LATENCY) @(posedge clk);
        if (board.mismatches == 0 && board.pending_quats.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
